[rtl/core/tbrp_pkg.sv]
// ----------------------------------------------------------------------------
// tbrp_pkg
// Shared types, sizes and helpers of the transmit byte ring packetizer.
// ----------------------------------------------------------------------------
package tbrp_pkg;

  localparam int RING_DEPTH = 256;
  localparam int PACKET_MAX = 64;

  localparam int PtrW = $clog2(RING_DEPTH);
  localparam int OccW = PtrW + 1;
  localparam int CntW = $clog2(PACKET_MAX + 1);
  localparam int ByteW = 8;

  typedef logic [PtrW-1:0] tbrp_ptr_t;
  typedef logic [CntW-1:0] tbrp_cnt_t;

  typedef enum logic [0:0] {
    OP_SEND = 1'b0,
    OP_DONE = 1'b1
  } tbrp_op_e;

  typedef struct packed {
    tbrp_op_e         opcode;
    logic [ByteW-1:0] send_byte;
  } tbrp_in_t;

  typedef struct packed {
    logic [ByteW-1:0] packet_byte;
    logic             packet_last;
  } tbrp_out_t;

  typedef struct packed {
    tbrp_cnt_t count;
  } tbrp_cmd_t;

  typedef struct packed {
    logic             we;
    tbrp_ptr_t        addr;
    logic [ByteW-1:0] data;
  } tbrp_wr_t;

  typedef struct packed {
    logic      re;
    tbrp_ptr_t addr;
  } tbrp_rd_t;

  function automatic tbrp_ptr_t ring_next(tbrp_ptr_t p);
    if (p == PtrW'(RING_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

endpackage

[rtl/core/tbrp_ram.sv]
// ----------------------------------------------------------------------------
// tbrp_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tbrp_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/tbrp_front.sv]
// ----------------------------------------------------------------------------
// tbrp_front
// Accepts words, writes bytes into the ring and sizes each packet to drain.
// ----------------------------------------------------------------------------
module tbrp_front
  import tbrp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  input  logic      cfg_data_i,
  input  logic      push_i,
  input  tbrp_in_t  item_i,
  output logic      full_o,
  input  tbrp_ptr_t prp_i,
  output tbrp_wr_t  wr_o,
  output logic      cmd_push_o,
  output tbrp_cmd_t cmd_o,
  input  logic      cmd_full_i
);

  logic      en_q, busy_q;
  tbrp_ptr_t wp_q, wp_d, lrp_q, lrp_d;
  logic      busy_d;
  tbrp_ptr_t nxt_wp;
  logic      log_full, phys_full, acc, do_write, live, drain;
  logic [OccW-1:0] occ, sum;
  tbrp_cnt_t cnt;

  assign nxt_wp    = ring_next(wp_q);
  assign log_full  = (nxt_wp == lrp_q);
  assign phys_full = (nxt_wp == prp_i);
  assign full_o    = cmd_full_i || (phys_full && !log_full);
  assign acc       = push_i && !full_o;
  assign do_write  = acc && (item_i.opcode == OP_SEND) && en_q && !log_full;
  assign live      = acc && ((item_i.opcode == OP_DONE) || en_q);

  always_comb begin
    wp_d   = do_write ? nxt_wp : wp_q;
    busy_d = (item_i.opcode == OP_DONE) ? 1'b0 : busy_q;
    if (wp_d >= lrp_q) begin
      occ = {1'b0, wp_d} - {1'b0, lrp_q};
    end else begin
      occ = {1'b0, wp_d} + OccW'(RING_DEPTH) - {1'b0, lrp_q};
    end
    cnt   = (int'(occ) > PACKET_MAX) ? CntW'(PACKET_MAX) : CntW'(occ);
    drain = live && !busy_d && (wp_d != lrp_q);
    sum   = {1'b0, lrp_q} + OccW'(cnt);
    if (int'(sum) >= RING_DEPTH) begin
      lrp_d = PtrW'(sum - OccW'(RING_DEPTH));
    end else begin
      lrp_d = sum[PtrW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= 1'b0;
      busy_q <= 1'b0;
      wp_q   <= '0;
      lrp_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        en_q <= cfg_data_i;
      end
      if (acc) begin
        wp_q <= wp_d;
      end
      if (live) begin
        busy_q <= drain ? 1'b1 : busy_d;
      end
      if (drain) begin
        lrp_q <= lrp_d;
      end
    end
  end

  assign wr_o.we     = do_write;
  assign wr_o.addr   = wp_q;
  assign wr_o.data   = item_i.send_byte;
  assign cmd_push_o  = drain;
  assign cmd_o.count = cnt;

endmodule

[rtl/core/tbrp_cmd_q.sv]
// ----------------------------------------------------------------------------
// tbrp_cmd_q
// Two-entry queue of packet commands between front and back.
// ----------------------------------------------------------------------------
module tbrp_cmd_q
  import tbrp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  tbrp_cmd_t cmd_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output tbrp_cmd_t cmd_o
);

  tbrp_cmd_t   ent_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = ent_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

[rtl/core/tbrp_back.sv]
// ----------------------------------------------------------------------------
// tbrp_back
// Reads each packet out of the ring and queues its bytes for the consumer.
// ----------------------------------------------------------------------------
module tbrp_back
  import tbrp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  tbrp_cmd_t        cmd_i,
  output logic             cmd_pop_o,
  output tbrp_rd_t         rd_o,
  input  logic [ByteW-1:0] rdata_i,
  output tbrp_ptr_t        prp_o,
  output logic             empty_o,
  input  logic             pop_i,
  output tbrp_out_t        item_o
);

  logic       active_q, rd_pend_q, rd_last_q;
  tbrp_cnt_t  remain_q;
  tbrp_ptr_t  prp_q;
  logic       load, issue, opush, opop;
  tbrp_out_t  oq_q [4];
  logic [1:0] owr_q, ord_q;
  logic [2:0] ocnt_q;

  assign load      = !active_q && cmd_valid_i;
  assign cmd_pop_o = load;
  assign issue     = active_q && ((ocnt_q + {2'b0, rd_pend_q}) < 3'd4);
  assign rd_o.re   = issue;
  assign rd_o.addr = prp_q;
  assign prp_o     = prp_q;
  assign opush     = rd_pend_q;
  assign opop      = pop_i && !empty_o;
  assign empty_o   = (ocnt_q == 3'd0);
  assign item_o    = oq_q[ord_q];

  always_ff @(posedge clk_i) begin
    if (opush) begin
      oq_q[owr_q] <= '{packet_byte: rdata_i, packet_last: rd_last_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      rd_pend_q <= 1'b0;
      rd_last_q <= 1'b0;
      remain_q  <= '0;
      prp_q     <= '0;
      owr_q     <= '0;
      ord_q     <= '0;
      ocnt_q    <= '0;
    end else begin
      rd_pend_q <= issue;
      rd_last_q <= issue && (remain_q == CntW'(1));
      if (load) begin
        active_q <= 1'b1;
        remain_q <= cmd_i.count;
      end else if (issue) begin
        remain_q <= remain_q - 1'b1;
        prp_q    <= ring_next(prp_q);
        if (remain_q == CntW'(1)) begin
          active_q <= 1'b0;
        end
      end
      if (opush) begin
        owr_q <= owr_q + 1'b1;
      end
      if (opop) begin
        ord_q <= ord_q + 1'b1;
      end
      ocnt_q <= ocnt_q + {2'b0, opush} - {2'b0, opop};
    end
  end

endmodule

[rtl/core/tx_byte_ring_packetizer.sv]
// ----------------------------------------------------------------------------
// tx_byte_ring_packetizer
// Byte ring with packet draining for the transmit side of a serial bridge.
//
//   channel   handshake          payload
//   input     push / full        in_item_i   (opcode, send_byte)
//   result    empty / pop        out_item_o  (packet_byte, packet_last)
//   config    cfg_valid/ready    cfg_data_i  (link_enable)
//
// One input word per cycle while full is low; a packet of N bytes leaves at one byte
// per cycle while the output queue has room, paced by the ring RAM read port.
// full rises while two packet commands wait, or while a write would land on
// ring bytes that the back end has not read out yet.
// Reset is asynchronous, active low; ring contents are not cleared.
// ----------------------------------------------------------------------------
module tx_byte_ring_packetizer
  import tbrp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i,
  input  logic      push,
  output logic      full,
  input  tbrp_in_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output tbrp_out_t out_item_o
);

  tbrp_wr_t         wr;
  tbrp_rd_t         rd;
  tbrp_ptr_t        prp;
  tbrp_cmd_t        cmd_in, cmd_out;
  logic             cmd_push, cmd_full, cmd_valid, cmd_pop;
  logic [ByteW-1:0] rdata;

  assign cfg_ready_o = 1'b1;

  tbrp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .item_i     (in_item_i),
    .full_o     (full),
    .prp_i      (prp),
    .wr_o       (wr),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .cmd_full_i (cmd_full)
  );

  tbrp_cmd_q u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .cmd_i  (cmd_in),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .valid_o(cmd_valid),
    .cmd_o  (cmd_out)
  );

  tbrp_ram #(
    .DEPTH(RING_DEPTH),
    .WIDTH(ByteW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr.we),
    .waddr_i(wr.addr),
    .wdata_i(wr.data),
    .re_i   (rd.re),
    .raddr_i(rd.addr),
    .rdata_o(rdata)
  );

  tbrp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .rd_o       (rd),
    .rdata_i    (rdata),
    .prp_o      (prp),
    .empty_o    (empty),
    .pop_i      (pop),
    .item_o     (out_item_o)
  );

  a_cmd_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !cmd_full)
    else $error("packet command pushed into a full queue");

  a_ring_no_clobber: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.we |-> (ring_next(wr.addr) != prp))
    else $error("ring write over unread byte");

  a_no_read_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr.we && rd.re) |-> (wr.addr != rd.addr))
    else $error("ring read and write hit the same entry");

endmodule
